[src/cmsc_pkg.sv]
`default_nettype none

package cmsc_pkg;

    // Sorting machine states, in the order of their mode codes.
    typedef enum logic [3:0] {
        MODE_START     = 4'd0,
        MODE_STANDBY   = 4'd1,
        MODE_READY     = 4'd2,
        MODE_TRANSPORT = 4'd3,
        MODE_REVERSE   = 4'd4,
        MODE_WAIT      = 4'd5,
        MODE_DETECT    = 4'd6,
        MODE_NONMETAL  = 4'd7,
        MODE_END       = 4'd8,
        MODE_METAL     = 4'd9,
        MODE_SLIDE     = 4'd10,
        MODE_ERROR     = 4'd11
    } t_mode;

    // Belt motor commands.
    typedef logic [1:0] t_drive;
    localparam t_drive DRIVE_STOP  = 2'd0;
    localparam t_drive DRIVE_RIGHT = 2'd1;
    localparam t_drive DRIVE_LEFT  = 2'd2;

    // Bit positions in the lamp and LED vectors.
    localparam int LAMP_GREEN  = 0;
    localparam int LAMP_RED    = 1;
    localparam int LAMP_YELLOW = 2;

    localparam int LED_START = 0;
    localparam int LED_Q1    = 1;
    localparam int LED_Q2    = 2;
    localparam int LED_RESET = 3;

    localparam logic [3:0] LEDS_IDLE = 4'b0001;

endpackage

`default_nettype wire

[src/conveyor_metal_sort_controller.sv]
// Conveyor metal-sorting controller. Each input word is one control scan of the
// sensor flags; each scan yields exactly one output word carrying the belt drive,
// lamps, button LEDs, junction and the state reached after the scan. The state
// machine and the output settings sit in one register stage that also serves as
// the output register, so a scan is answered in the cycle after it is accepted and a
// new scan is taken every cycle while the output side keeps up (o_in_ready is high
// whenever the output register is empty or being read in the same cycle). Outputs
// a state does not set keep their previous values; after reset the first scan
// always moves the machine from start to standby.
`default_nettype none

module conveyor_metal_sort_controller (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Scan input channel.
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic                  i_start_released,
    input  wire logic                  i_at_begin,
    input  wire logic                  i_at_end,
    input  wire logic                  i_at_height,
    input  wire logic                  i_at_metal_sensor,
    input  wire logic                  i_is_metal,
    input  wire logic                  i_passed_slide,
    input  wire logic                  i_reverse_request,
    input  wire logic                  i_second_parity,
    // Result channel.
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      cmsc_pkg::t_drive      o_drive,
    output      logic                  o_lamp_green,
    output      logic                  o_lamp_red,
    output      logic                  o_lamp_yellow,
    output      logic                  o_led_start,
    output      logic                  o_led_q1,
    output      logic                  o_led_q2,
    output      logic                  o_led_reset,
    output      logic                  o_junction_open,
    output      logic [3:0]            o_mode
);

    import cmsc_pkg::*;

    t_mode      r_mode,     n_mode;
    t_drive     r_drive,    n_drive;
    logic [2:0] r_lamps,    n_lamps;
    logic [3:0] r_leds,     n_leds;
    logic       r_junction, n_junction;
    logic       r_out_valid;
    logic       w_accept;

    // A scan is taken when the output register is free or drains this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state; within a state a later test overrides an earlier one.
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_START: begin
                n_mode = MODE_STANDBY;
            end
            MODE_STANDBY: begin
                if (i_start_released) n_mode = MODE_READY;
            end
            MODE_READY: begin
                if (i_start_released) n_mode = MODE_STANDBY;
                if (i_at_begin && !i_at_end) n_mode = MODE_TRANSPORT;
                if (i_at_height || i_at_metal_sensor) n_mode = MODE_ERROR;
            end
            MODE_TRANSPORT: begin
                if (i_reverse_request) n_mode = MODE_REVERSE;
                if (i_at_metal_sensor) n_mode = MODE_DETECT;
                if (i_at_end) n_mode = MODE_ERROR;
            end
            MODE_REVERSE: begin
                if (i_at_begin) n_mode = MODE_WAIT;
            end
            MODE_WAIT: begin
                if (!i_at_begin) n_mode = MODE_READY;
            end
            MODE_DETECT: begin
                n_mode = i_is_metal ? MODE_METAL : MODE_NONMETAL;
            end
            MODE_NONMETAL: begin
                if (i_at_end) n_mode = MODE_END;
                if (i_at_begin || i_at_height) n_mode = MODE_ERROR;
            end
            MODE_END: begin
                if (i_start_released) n_mode = MODE_STANDBY;
                if (!i_at_end) n_mode = MODE_READY;
                if (i_at_metal_sensor || i_at_height) n_mode = MODE_ERROR;
            end
            MODE_METAL: begin
                if (i_passed_slide) n_mode = MODE_SLIDE;
                if (i_at_begin || i_at_height) n_mode = MODE_ERROR;
            end
            MODE_SLIDE: begin
                if (i_start_released) n_mode = MODE_STANDBY;
                if (i_at_begin) n_mode = MODE_TRANSPORT;
                if (i_at_end || i_at_height) n_mode = MODE_ERROR;
            end
            MODE_ERROR: begin
                if (i_start_released) n_mode = MODE_STANDBY;
            end
            default: begin
                n_mode = MODE_START;
            end
        endcase
    end

    // Outputs of the new state; anything a state leaves alone holds.
    always_comb begin
        n_drive    = r_drive;
        n_lamps    = r_lamps;
        n_leds     = r_leds;
        n_junction = r_junction;
        unique case (n_mode)
            MODE_START, MODE_STANDBY: begin
                n_drive = DRIVE_STOP;
                n_lamps = 3'b000;
                n_leds  = LEDS_IDLE;
            end
            MODE_READY: begin
                n_drive               = DRIVE_STOP;
                n_lamps               = 3'b000;
                n_lamps[LAMP_GREEN]   = 1'b1;
                n_leds[LED_START]     = 1'b1;
            end
            MODE_TRANSPORT: begin
                n_drive               = DRIVE_RIGHT;
                n_lamps               = 3'b000;
                n_lamps[LAMP_GREEN]   = 1'b1;
                n_leds[LED_START]     = 1'b0;
            end
            MODE_REVERSE: begin
                n_drive               = DRIVE_LEFT;
                n_lamps[LAMP_RED]     = i_second_parity;
                n_lamps[LAMP_GREEN]   = 1'b0;
            end
            MODE_WAIT: begin
                n_drive               = DRIVE_STOP;
                n_lamps[LAMP_RED]     = 1'b1;
            end
            MODE_DETECT: begin
                n_drive               = DRIVE_STOP;
                n_lamps               = 3'b000;
                n_lamps[LAMP_GREEN]   = 1'b1;
            end
            MODE_NONMETAL: begin
                n_drive               = DRIVE_RIGHT;
                n_lamps               = 3'b000;
                n_lamps[LAMP_GREEN]   = 1'b1;
                n_leds[LED_START]     = 1'b0;
                n_junction            = 1'b1;
            end
            MODE_END: begin
                n_drive               = DRIVE_STOP;
                n_lamps               = 3'b000;
                n_lamps[LAMP_GREEN]   = i_second_parity;
                n_leds[LED_START]     = 1'b1;
                n_junction            = 1'b0;
            end
            MODE_METAL: begin
                n_drive               = DRIVE_RIGHT;
                n_lamps               = 3'b000;
                n_lamps[LAMP_YELLOW]  = 1'b1;
            end
            MODE_SLIDE: begin
                n_drive               = DRIVE_STOP;
                n_lamps               = 3'b000;
                n_lamps[LAMP_GREEN]   = 1'b1;
                n_leds[LED_START]     = 1'b1;
            end
            default: begin
                // Error: red blinks, belt stopped, junction closed.
                n_drive               = DRIVE_STOP;
                n_lamps               = 3'b000;
                n_lamps[LAMP_RED]     = i_second_parity;
                n_leds[LED_START]     = 1'b1;
                n_junction            = 1'b0;
            end
        endcase
    end

    // State registers double as the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_START;
            r_drive     <= DRIVE_STOP;
            r_lamps     <= 3'b000;
            r_leds      <= 4'b0000;
            r_junction  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mode     <= n_mode;
                r_drive    <= n_drive;
                r_lamps    <= n_lamps;
                r_leds     <= n_leds;
                r_junction <= n_junction;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;
    assign o_lamp_green    = r_lamps[LAMP_GREEN];
    assign o_lamp_red      = r_lamps[LAMP_RED];
    assign o_lamp_yellow   = r_lamps[LAMP_YELLOW];
    assign o_led_start     = r_leds[LED_START];
    assign o_led_q1        = r_leds[LED_Q1];
    assign o_led_q2        = r_leds[LED_Q2];
    assign o_led_reset     = r_leds[LED_RESET];
    assign o_junction_open = r_junction;
    assign o_mode          = r_mode;

endmodule

`default_nettype wire

[src/cmsc_checker.sv]
`default_nettype none

module cmsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_drive,
    input wire logic       o_lamp_green,
    input wire logic       o_lamp_red,
    input wire logic       o_lamp_yellow,
    input wire logic       o_led_start,
    input wire logic       o_led_q1,
    input wire logic       o_led_q2,
    input wire logic       o_led_reset,
    input wire logic       o_junction_open,
    input wire logic [3:0] o_mode
);

    import cmsc_pkg::*;

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_mode)
            && $stable(o_drive) && $stable(o_junction_open)))
        else $error("stalled result word changed");

    // Every accepted scan produces a result word in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted scan gave no result word");

    // Standby shows stopped belt, dark lamps and only the start LED.
    a_standby_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mode == MODE_STANDBY) |->
            (o_drive == DRIVE_STOP && !o_lamp_green && !o_lamp_red
             && !o_lamp_yellow && o_led_start))
        else $error("standby outputs wrong");

    // No state ever lights the Q1, Q2 or reset LEDs.
    a_leds_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_led_q1 && !o_led_q2 && !o_led_reset))
        else $error("Q1, Q2 or reset LED lit");

    // The belt runs only in transport, reverse, nonmetal or metal.
    a_drive_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive != DRIVE_STOP) |->
            (o_mode == MODE_TRANSPORT || o_mode == MODE_REVERSE
             || o_mode == MODE_NONMETAL || o_mode == MODE_METAL))
        else $error("belt running in a stopped state");

endmodule

bind conveyor_metal_sort_controller cmsc_checker u_cmsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_drive         (o_drive),
    .o_lamp_green    (o_lamp_green),
    .o_lamp_red      (o_lamp_red),
    .o_lamp_yellow   (o_lamp_yellow),
    .o_led_start     (o_led_start),
    .o_led_q1        (o_led_q1),
    .o_led_q2        (o_led_q2),
    .o_led_reset     (o_led_reset),
    .o_junction_open (o_junction_open),
    .o_mode          (o_mode)
);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import cmsc_pkg::*;

    // One sensor scan as it enters the controller.
    typedef struct packed {
        logic start_released;
        logic at_begin;
        logic at_end;
        logic at_height;
        logic at_metal_sensor;
        logic is_metal;
        logic passed_slide;
        logic reverse_request;
        logic second_parity;
    } t_scan;

    // One output word as it leaves the controller.
    typedef struct packed {
        t_drive     drive;
        logic       lamp_green;
        logic       lamp_red;
        logic       lamp_yellow;
        logic       led_start;
        logic       led_q1;
        logic       led_q2;
        logic       led_reset;
        logic       junction_open;
        logic [3:0] mode;
    } t_outputs;

    localparam int IDLE_PCT      = 28;
    localparam int RANDOM_SCANS  = 900;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the sorting machine and compares every output word in order.
    class sorter_scoreboard;
        t_mode      mode;
        t_drive     drive;
        logic [2:0] lamps;
        logic [3:0] leds;
        logic       junction;
        t_outputs   pending_outputs[$];
        int         mismatches;

        function new();
            mode       = MODE_START;
            drive      = DRIVE_STOP;
            lamps      = 3'b000;
            leds       = 4'b0000;
            junction   = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // Moves the machine by one accepted scan and queues the word it must produce.
        function void note_scan(t_scan s);
            t_mode    nxt;
            t_outputs w;
            nxt = mode;
            // Later tests override earlier ones within a state.
            case (mode)
                MODE_START: nxt = MODE_STANDBY;
                MODE_STANDBY: begin
                    if (s.start_released) nxt = MODE_READY;
                end
                MODE_READY: begin
                    if (s.start_released) nxt = MODE_STANDBY;
                    if (s.at_begin && !s.at_end) nxt = MODE_TRANSPORT;
                    if (s.at_height || s.at_metal_sensor) nxt = MODE_ERROR;
                end
                MODE_TRANSPORT: begin
                    if (s.reverse_request) nxt = MODE_REVERSE;
                    if (s.at_metal_sensor) nxt = MODE_DETECT;
                    if (s.at_end) nxt = MODE_ERROR;
                end
                MODE_REVERSE: begin
                    if (s.at_begin) nxt = MODE_WAIT;
                end
                MODE_WAIT: begin
                    if (!s.at_begin) nxt = MODE_READY;
                end
                MODE_DETECT: nxt = s.is_metal ? MODE_METAL : MODE_NONMETAL;
                MODE_NONMETAL: begin
                    if (s.at_end) nxt = MODE_END;
                    if (s.at_begin || s.at_height) nxt = MODE_ERROR;
                end
                MODE_END: begin
                    if (s.start_released) nxt = MODE_STANDBY;
                    if (!s.at_end) nxt = MODE_READY;
                    if (s.at_metal_sensor || s.at_height) nxt = MODE_ERROR;
                end
                MODE_METAL: begin
                    if (s.passed_slide) nxt = MODE_SLIDE;
                    if (s.at_begin || s.at_height) nxt = MODE_ERROR;
                end
                MODE_SLIDE: begin
                    if (s.start_released) nxt = MODE_STANDBY;
                    if (s.at_begin) nxt = MODE_TRANSPORT;
                    if (s.at_end || s.at_height) nxt = MODE_ERROR;
                end
                MODE_ERROR: begin
                    if (s.start_released) nxt = MODE_STANDBY;
                end
                default: nxt = MODE_START;
            endcase
            mode = nxt;

            // Outputs of the new state; anything a state leaves alone holds its value.
            case (mode)
                MODE_START, MODE_STANDBY: begin
                    drive = DRIVE_STOP;
                    lamps = 3'b000;
                    leds  = LEDS_IDLE;
                end
                MODE_READY, MODE_TRANSPORT, MODE_DETECT, MODE_NONMETAL, MODE_SLIDE: begin
                    drive = (mode == MODE_TRANSPORT || mode == MODE_NONMETAL) ?
                            DRIVE_RIGHT : DRIVE_STOP;
                    lamps[LAMP_GREEN]  = 1'b1;
                    lamps[LAMP_RED]    = 1'b0;
                    lamps[LAMP_YELLOW] = 1'b0;
                    if (mode == MODE_READY || mode == MODE_SLIDE) begin
                        leds[LED_START] = 1'b1;
                    end
                    if (mode == MODE_TRANSPORT || mode == MODE_NONMETAL) begin
                        leds[LED_START] = 1'b0;
                    end
                    if (mode == MODE_NONMETAL) begin
                        junction = 1'b1;
                    end
                end
                MODE_REVERSE: begin
                    drive = DRIVE_LEFT;
                    lamps[LAMP_RED]   = s.second_parity;
                    lamps[LAMP_GREEN] = 1'b0;
                end
                MODE_WAIT: begin
                    drive = DRIVE_STOP;
                    lamps[LAMP_RED] = 1'b1;
                end
                MODE_END: begin
                    drive = DRIVE_STOP;
                    lamps[LAMP_RED]    = 1'b0;
                    lamps[LAMP_YELLOW] = 1'b0;
                    lamps[LAMP_GREEN]  = s.second_parity;
                    leds[LED_START]    = 1'b1;
                    junction = 1'b0;
                end
                MODE_METAL: begin
                    drive = DRIVE_RIGHT;
                    lamps[LAMP_GREEN]  = 1'b0;
                    lamps[LAMP_RED]    = 1'b0;
                    lamps[LAMP_YELLOW] = 1'b1;
                end
                default: begin
                    // Error: red blinks with the seconds parity.
                    drive = DRIVE_STOP;
                    lamps[LAMP_GREEN]  = 1'b0;
                    lamps[LAMP_YELLOW] = 1'b0;
                    lamps[LAMP_RED]    = s.second_parity;
                    leds[LED_START]    = 1'b1;
                    junction = 1'b0;
                end
            endcase

            w.drive         = drive;
            w.lamp_green    = lamps[LAMP_GREEN];
            w.lamp_red      = lamps[LAMP_RED];
            w.lamp_yellow   = lamps[LAMP_YELLOW];
            w.led_start     = leds[LED_START];
            w.led_q1        = leds[LED_Q1];
            w.led_q2        = leds[LED_Q2];
            w.led_reset     = leds[LED_RESET];
            w.junction_open = junction;
            w.mode          = mode;
            pending_outputs.push_back(w);
        endfunction

        // Compares one output word with the oldest expected word.
        function void check_word(t_outputs got);
            t_outputs exp_w;
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected output word: drive=%0d mode=%0d", got.drive, got.mode);
                end
                return;
            end
            exp_w = pending_outputs.pop_front();
            if (got.drive !== exp_w.drive || got.lamp_green !== exp_w.lamp_green ||
                got.lamp_red !== exp_w.lamp_red || got.lamp_yellow !== exp_w.lamp_yellow ||
                got.led_start !== exp_w.led_start || got.led_q1 !== exp_w.led_q1 ||
                got.led_q2 !== exp_w.led_q2 || got.led_reset !== exp_w.led_reset ||
                got.junction_open !== exp_w.junction_open || got.mode !== exp_w.mode) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("word mismatch: drive %0d/%0d gry %b%b%b/%b%b%b",
                             exp_w.drive, got.drive,
                             exp_w.lamp_green, exp_w.lamp_red, exp_w.lamp_yellow,
                             got.lamp_green, got.lamp_red, got.lamp_yellow);
                    $display("  leds s/q1/q2/r %b%b%b%b/%b%b%b%b jct %b/%b mode %0d/%0d",
                             exp_w.led_start, exp_w.led_q1, exp_w.led_q2, exp_w.led_reset,
                             got.led_start, got.led_q1, got.led_q2, got.led_reset,
                             exp_w.junction_open, got.junction_open, exp_w.mode, got.mode);
                end
            end
        endfunction
    endclass

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_in_valid        = 1'b0;
    logic       i_out_ready       = 1'b0;
    logic       i_start_released  = 1'b0;
    logic       i_at_begin        = 1'b0;
    logic       i_at_end          = 1'b0;
    logic       i_at_height       = 1'b0;
    logic       i_at_metal_sensor = 1'b0;
    logic       i_is_metal        = 1'b0;
    logic       i_passed_slide    = 1'b0;
    logic       i_reverse_request = 1'b0;
    logic       i_second_parity   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_drive     o_drive;
    logic       o_lamp_green;
    logic       o_lamp_red;
    logic       o_lamp_yellow;
    logic       o_led_start;
    logic       o_led_q1;
    logic       o_led_q2;
    logic       o_led_reset;
    logic       o_junction_open;
    logic [3:0] o_mode;

    sorter_scoreboard sb = new();
    bit               calm = 1'b0;
    int               quiet_cycles = 0;

    conveyor_metal_sort_controller u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_start_released  (i_start_released),
        .i_at_begin        (i_at_begin),
        .i_at_end          (i_at_end),
        .i_at_height       (i_at_height),
        .i_at_metal_sensor (i_at_metal_sensor),
        .i_is_metal        (i_is_metal),
        .i_passed_slide    (i_passed_slide),
        .i_reverse_request (i_reverse_request),
        .i_second_parity   (i_second_parity),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_drive           (o_drive),
        .o_lamp_green      (o_lamp_green),
        .o_lamp_red        (o_lamp_red),
        .o_lamp_yellow     (o_lamp_yellow),
        .o_led_start       (o_led_start),
        .o_led_q1          (o_led_q1),
        .o_led_q2          (o_led_q2),
        .o_led_reset       (o_led_reset),
        .o_junction_open   (o_junction_open),
        .o_mode            (o_mode)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Offers one scan after an optional random gap and waits until it is taken.
    task automatic send_scan(input t_scan s);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_start_released  <= s.start_released;
        i_at_begin        <= s.at_begin;
        i_at_end          <= s.at_end;
        i_at_height       <= s.at_height;
        i_at_metal_sensor <= s.at_metal_sensor;
        i_is_metal        <= s.is_metal;
        i_passed_slide    <= s.passed_slide;
        i_reverse_request <= s.reverse_request;
        i_second_parity   <= s.second_parity;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_scan(s);
    endtask

    // Mostly plausible sensor patterns for the current state, with some raw noise.
    function automatic t_scan next_scan(t_mode m);
        t_scan       s;
        logic [31:0] raw;
        int          r;
        raw = $urandom;
        s   = raw[8:0];
        if ($urandom_range(99) < 20) begin
            return s;
        end
        s = '0;
        s.second_parity = raw[9];
        r = $urandom_range(99);
        case (m)
            MODE_STANDBY: s.start_released = (r < 60);
            MODE_READY: begin
                if (r < 65) s.at_begin = 1'b1;
                else if (r < 72) begin
                    s.at_begin = 1'b1;
                    s.at_end   = 1'b1;
                end
                else if (r < 84) s.start_released = 1'b1;
                else if (r < 90) s.at_height = 1'b1;
                else if (r < 95) s.at_metal_sensor = 1'b1;
            end
            MODE_TRANSPORT: begin
                if (r < 50) s.at_metal_sensor = 1'b1;
                else if (r < 70) s.reverse_request = 1'b1;
                else if (r < 78) s.at_end = 1'b1;
            end
            MODE_REVERSE: s.at_begin = (r < 50);
            MODE_WAIT: s.at_begin = (r < 50);
            MODE_DETECT: s.is_metal = raw[10];
            MODE_NONMETAL: begin
                if (r < 55) s.at_end = 1'b1;
                else if (r < 62) s.at_begin = 1'b1;
                else if (r < 68) s.at_height = 1'b1;
            end
            MODE_END: begin
                s.at_end = (r < 40);
                if (r >= 85) s.start_released = 1'b1;
                if (r >= 93) s.at_metal_sensor = 1'b1;
                if (r < 5) s.at_height = 1'b1;
            end
            MODE_METAL: begin
                if (r < 55) s.passed_slide = 1'b1;
                else if (r < 62) s.at_begin = 1'b1;
                else if (r < 68) s.at_height = 1'b1;
            end
            MODE_SLIDE: begin
                if (r < 45) s.at_begin = 1'b1;
                else if (r < 65) s.start_released = 1'b1;
                else if (r < 72) s.at_end = 1'b1;
                else if (r < 78) s.at_height = 1'b1;
            end
            MODE_ERROR: s.start_released = (r < 40);
            default: s = raw[8:0];
        endcase
        return s;
    endfunction

    // Result side: take words when ready, stall at random outside the calm stretch.
    always @(posedge i_clk) begin
        t_outputs got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.drive         = o_drive;
            got.lamp_green    = o_lamp_green;
            got.lamp_red      = o_lamp_red;
            got.lamp_yellow   = o_lamp_yellow;
            got.led_start     = o_led_start;
            got.led_q1        = o_led_q1;
            got.led_q2        = o_led_q2;
            got.led_reset     = o_led_reset;
            got.junction_open = o_junction_open;
            got.mode          = o_mode;
            sb.check_word(got);
        end
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk every state along one path of transitions, with both seconds parities where lamps blink.
        send_scan('1);
        send_scan('0);
        send_scan(t_scan'{start_released: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_begin: 1'b1, default: 1'b0});
        send_scan(t_scan'{reverse_request: 1'b1, second_parity: 1'b1, default: 1'b0});
        send_scan(t_scan'{reverse_request: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_begin: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_begin: 1'b1, second_parity: 1'b1, default: 1'b0});
        send_scan('0);
        send_scan(t_scan'{at_begin: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_metal_sensor: 1'b1, default: 1'b0});
        send_scan('0);
        send_scan(t_scan'{at_end: 1'b1, second_parity: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_end: 1'b1, default: 1'b0});
        send_scan('0);
        send_scan(t_scan'{at_begin: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_metal_sensor: 1'b1, default: 1'b0});
        send_scan(t_scan'{is_metal: 1'b1, default: 1'b0});
        send_scan(t_scan'{passed_slide: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_begin: 1'b1, default: 1'b0});
        send_scan(t_scan'{at_end: 1'b1, second_parity: 1'b1, default: 1'b0});
        send_scan('0);
        send_scan(t_scan'{start_released: 1'b1, default: 1'b0});
        send_scan('1);
        send_scan('1);

        // Random scans shaped by the predicted state; a middle stretch runs without gaps.
        for (int n = 0; n < RANDOM_SCANS; n++) begin
            calm = (n >= 300 && n < 450);
            send_scan(next_scan(sb.mode));
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
